// ===== src/bdlp_pkg.sv =====
// package for the button debouncer with long-press and auto-repeat events
// register map, reset values and field widths; no dependencies
`timescale 1ns / 1ps

package bdlp_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned MsW    = 16;
	localparam int unsigned DataW  = 32;
	localparam int unsigned AddrW  = 4;

	// register indexes, byte address is 4 * index
	typedef enum logic [1:0] {
		REG_INVERT_LEVEL   = 2'd0,
		REG_LONG_PRESS     = 2'd1,
		REG_REPEAT_INTERVAL = 2'd2,
		REG_DEBOUNCE       = 2'd3
	} reg_idx_t;

	localparam logic           InvertLevelRst   = 1'b1;
	localparam logic [MsW-1:0] LongPressRst     = 16'd1000;
	localparam logic [MsW-1:0] RepeatIntervalRst = 16'd200;
	localparam logic [MsW-1:0] DebounceRst      = 16'd50;

	// one result item
	typedef struct packed {
		logic pressed;
		logic down_event;
		logic up_event;
		logic long_press_event;
		logic repeat_event;
	} result_t;

endpackage

// ===== src/button_debounce_long_press_repeat.sv =====
// top level of the button debouncer with long-press and auto-repeat events
// holds the input register, the event logic, the result register and the apb registers
// depends on bdlp_pkg
`timescale 1ns / 1ps

// channel  direction  handshake                     payload
// in       sink       in_valid / in_stall           pin_level, now_ms
// out      source     out_valid / out_stall         pressed, down_event, up_event,
//                                                   long_press_event, repeat_event
// cfg      apb slave  psel / penable / pready       paddr, pwrite, pwdata, prdata
//
// one item per clock cycle sustained while out_stall is low; an item passes through
// the input register, then the result register, with the event logic between them
// the debounce state updates as an item moves into the result register, so the
// next item in the input register always sees it
// arst_n clears both valid flags, the debounce state and the registers to defaults
// a stalled result holds; the input register fills behind it, then in_stall rises

module button_debounce_long_press_repeat (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        pin_level,
	input  logic [bdlp_pkg::TimeW-1:0]  now_ms,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        pressed,
	output logic                        down_event,
	output logic                        up_event,
	output logic                        long_press_event,
	output logic                        repeat_event,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdlp_pkg::AddrW-1:0]  paddr,
	input  logic [bdlp_pkg::DataW-1:0]  pwdata,
	output logic [bdlp_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import bdlp_pkg::*;

	// configuration registers
	logic           invert_level_q;
	logic [MsW-1:0] long_press_ms_q;
	logic [MsW-1:0] repeat_interval_ms_q;
	logic [MsW-1:0] debounce_ms_q;

	// debounce and hold state
	logic             last_pressed_q;
	logic [TimeW-1:0] last_change_time_q;
	logic [TimeW-1:0] press_time_q;
	logic             long_press_fired_q;
	logic [TimeW-1:0] repeat_offset_q;

	// input register
	logic             valid_s1;
	logic             pin_level_s1;
	logic [TimeW-1:0] now_ms_s1;

	// result register
	logic    out_valid_q;
	result_t result_q;

	logic     out_adv;
	logic     s1_adv;
	reg_idx_t reg_idx;
	logic     cfg_write;

	// ---------------- apb port ----------------
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_level_q       <= InvertLevelRst;
			long_press_ms_q      <= LongPressRst;
			repeat_interval_ms_q <= RepeatIntervalRst;
			debounce_ms_q        <= DebounceRst;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_INVERT_LEVEL:    invert_level_q       <= pwdata[0];
				REG_LONG_PRESS:      long_press_ms_q      <= pwdata[MsW-1:0];
				REG_REPEAT_INTERVAL: repeat_interval_ms_q <= pwdata[MsW-1:0];
				REG_DEBOUNCE:        debounce_ms_q        <= pwdata[MsW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INVERT_LEVEL:    prdata = {{(DataW-1){1'b0}}, invert_level_q};
			REG_LONG_PRESS:      prdata = {{(DataW-MsW){1'b0}}, long_press_ms_q};
			REG_REPEAT_INTERVAL: prdata = {{(DataW-MsW){1'b0}}, repeat_interval_ms_q};
			REG_DEBOUNCE:        prdata = {{(DataW-MsW){1'b0}}, debounce_ms_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	// result register frees when empty or taken this cycle
	assign out_adv  = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_adv;
	assign in_stall = valid_s1 && !out_adv;

	// ---------------- event logic ----------------
	logic             cur;
	logic             changed;
	logic [TimeW-1:0] limit;
	logic             bounce;
	logic             is_down;
	logic             is_up;
	logic             is_held;
	logic [TimeW-1:0] base;
	logic             lp_hit;
	logic             fired_nx;
	logic [TimeW-1:0] since;
	logic [TimeW:0]   next_offset;
	logic             rep_hit;
	result_t          result_nx;

	always_comb begin
		cur     = pin_level_s1 ^ invert_level_q;
		changed = cur != last_pressed_q;
		// wrapping sum, compared as plain unsigned
		limit   = last_change_time_q + {{(TimeW-MsW){1'b0}}, debounce_ms_q};
		bounce  = changed && (now_ms_s1 < limit);

		is_down = !bounce && cur && !last_pressed_q;
		is_up   = !bounce && !cur && last_pressed_q;
		is_held = cur && last_pressed_q;

		base     = press_time_q + {{(TimeW-MsW){1'b0}}, long_press_ms_q};
		lp_hit   = is_held && (now_ms_s1 > base) && !long_press_fired_q;
		fired_nx = long_press_fired_q || lp_hit;
		since    = now_ms_s1 - base;
		// one bit wider so an offset past 32 bits stops the repeats
		next_offset = {1'b0, repeat_offset_q} + {{(TimeW+1-MsW){1'b0}}, repeat_interval_ms_q};
		rep_hit     = is_held && fired_nx && ({1'b0, since} >= next_offset);

		result_nx.pressed          = bounce ? last_pressed_q : cur;
		result_nx.down_event       = is_down;
		result_nx.up_event         = is_up;
		result_nx.long_press_event = lp_hit;
		result_nx.repeat_event     = rep_hit;
	end

	// ---------------- state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pressed_q     <= 1'b0;
			last_change_time_q <= '0;
			press_time_q       <= '0;
			long_press_fired_q <= 1'b0;
			repeat_offset_q    <= '0;
		end else if (s1_adv && !bounce) begin
			last_pressed_q <= cur;
			if (changed) begin
				last_change_time_q <= now_ms_s1;
			end
			if (is_down) begin
				press_time_q <= now_ms_s1;
			end
			if (is_up) begin
				long_press_fired_q <= 1'b0;
				repeat_offset_q    <= '0;
			end else if (is_held) begin
				long_press_fired_q <= fired_nx;
				if (rep_hit) begin
					repeat_offset_q <= next_offset[TimeW-1:0];
				end
			end
		end
	end

	// ---------------- pipeline registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_level_s1 <= pin_level;
			now_ms_s1    <= now_ms;
		end
		if (s1_adv) begin
			result_q <= result_nx;
		end
	end

	assign out_valid        = out_valid_q;
	assign pressed          = result_q.pressed;
	assign down_event       = result_q.down_event;
	assign up_event         = result_q.up_event;
	assign long_press_event = result_q.long_press_event;
	assign repeat_event     = result_q.repeat_event;

	// ---------------- assertions ----------------
	a_down_up_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(down_event && up_event))
		else $error("down and up event in one item");

	a_event_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (down_event || long_press_event || repeat_event) |-> pressed)
		else $error("press event while not pressed");

	a_up_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && up_event |-> !pressed && !long_press_event && !repeat_event)
		else $error("release item carries hold events");

	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule
